>>> hw/rtl/stir_pkg.sv
// Package for the sorted table block: request and result structs, kind and status codes.
// Holds the default capacity and the control struct passed to every table cell.
// No dependencies.
package stir_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int INDEX_W      = 4;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     read_value;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [1:0]             status;
  } rsp_t;

  typedef struct packed {
    logic               ins;
    logic               rep;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
  } cell_op_t;

endpackage

>>> hw/rtl/stir_cell.sv
// One position of the sorted table: holds an entry and shifts or loads it on update.
// Exchanges entries and comparison flags with its two neighbors.
// Depends on stir_pkg.
module stir_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 5
) (
  input  logic                         clk,
  input  stir_pkg::cell_op_t           op,
  input  logic [CNT_W-1:0]             count,
  input  logic [stir_pkg::VALUE_W-1:0] left_entry,
  input  logic [stir_pkg::VALUE_W-1:0] right_entry,
  input  logic                         left_gt,
  output logic [stir_pkg::VALUE_W-1:0] entry,
  output logic                         gt,
  output logic [stir_pkg::VALUE_W-1:0] rd_part
);
  import stir_pkg::*;

  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CMP_W-1:0] POS_C = CMP_W'(POS);

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;
  logic [VALUE_W-1:0] a_here;
  logic [VALUE_W-1:0] a_left;
  logic [CMP_W-1:0]   idx_c;
  logic [CMP_W-1:0]   cnt_c;
  logic [CMP_W-1:0]   limit;

  // For a replace, the table is first closed up over the removed position,
  // then the new value is inserted in order.
  always_comb begin
    idx_c  = CMP_W'(op.idx);
    cnt_c  = CMP_W'(count);
    limit  = op.rep ? (cnt_c - CMP_W'(1)) : cnt_c;
    a_here = (op.rep && (POS_C >= idx_c)) ? right_entry : entry_r;
    a_left = (op.rep && (POS_C > idx_c)) ? entry_r : left_entry;
    gt     = (POS_C >= limit) || (a_here > op.value);
    if (left_gt) begin
      entry_nxt = a_left;
    end else if (gt) begin
      entry_nxt = op.value;
    end else begin
      entry_nxt = a_here;
    end
    rd_part = (POS_C == idx_c) ? entry_r : '0;
  end

  always_ff @(posedge clk) begin
    if (op.ins || op.rep) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

>>> hw/rtl/sorted_table_insert_replace_read.sv
// Top level of the sorted table: request and result channels, entry count, row of cells.
// Depends on stir_pkg and stir_cell.
//
// The block keeps up to CAPACITY unsigned 32-bit entries in ascending order.
// A request on the in_ channel is taken when in_valid is high and in_stall is low.
// An insert places its value in order, a replace removes the entry at the index
// and inserts the new value, and a read returns the entry at the index.
// Every request gives exactly one result on the out_ channel with the entry
// count after the request and a status: ok, index out of range, or table full.
// Each cell compares its entry with the new value and takes its own entry, the
// new value or a neighbor's entry, so all cells of the table update together.
// The result is registered and appears in the cycle after the request is taken.
// One request is taken in every cycle while the receiver does not stall.
// While out_stall holds a waiting result, in_stall is high and the result stays.
// Reset empties the table and drops any waiting result; no clearing pass is needed.
module sorted_table_insert_replace_read #(
  parameter int CAPACITY = stir_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  stir_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output stir_pkg::rsp_t out_rsp
);
  import stir_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  rsp_t               rsp_r;
  rsp_t               rsp_nxt;
  logic               accept;
  logic               full;
  logic               in_range;
  cell_op_t           op;
  logic [VALUE_W-1:0] entries [CAPACITY];
  logic [VALUE_W-1:0] rd_parts [CAPACITY];
  logic [VALUE_W-1:0] rd_acc [CAPACITY+1];
  logic               gts [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign in_range = CMP_W'(in_req.index) < CMP_W'(count_r);

  assign rd_acc[0] = '0;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_e;
      logic [VALUE_W-1:0] right_e;
      logic               left_g;
      if (i == 0) begin : g_first
        assign left_e = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_e = entries[i-1];
        assign left_g = gts[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = entries[i+1];
      end
      stir_cell #(
        .POS   (i),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk         (clk),
        .op          (op),
        .count       (count_r),
        .left_entry  (left_e),
        .right_entry (right_e),
        .left_gt     (left_g),
        .entry       (entries[i]),
        .gt          (gts[i]),
        .rd_part     (rd_parts[i])
      );
      assign rd_acc[i+1] = rd_acc[i] | rd_parts[i];
    end
  endgenerate

  always_comb begin
    op.ins    = 1'b0;
    op.rep    = 1'b0;
    op.idx    = in_req.index;
    op.value  = in_req.value;
    count_nxt = count_r;
    rsp_nxt.read_value = '0;
    rsp_nxt.status     = ST_OK;
    case (kind_t'(in_req.kind))
      KIND_INSERT: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          op.ins    = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REPLACE: begin
        if (in_range) begin
          op.rep = accept;
        end else begin
          rsp_nxt.status = ST_RANGE;
        end
      end
      KIND_READ: begin
        if (in_range) begin
          rsp_nxt.read_value = rd_acc[CAPACITY];
        end else begin
          rsp_nxt.status = ST_RANGE;
        end
      end
      default: begin
        rsp_nxt.status = ST_OK;
      end
    endcase
    rsp_nxt.entry_count = COUNT_OUT_W'(count_nxt);
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

>>> bench/sorted_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted table block: watches the request and result channels.
// Keeps a shadow copy of the table, predicts each result and compares it field by field.
// Depends on stir_pkg.
module sorted_table_checker #(
  parameter int CAPACITY = stir_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  stir_pkg::req_t in_req,
  input  logic           out_valid,
  input  logic           out_stall,
  input  stir_pkg::rsp_t out_rsp,
  output int             errors,
  output int             outstanding,
  output int             checked
);
  import stir_pkg::*;

  logic [VALUE_W-1:0] shadow_entries [CAPACITY];
  int                 shadow_count;
  rsp_t               expected_rsps [$];

  function automatic void place_in_order(logic [VALUE_W-1:0] v);
    int pos;
    pos = shadow_count;
    while (pos > 0 && shadow_entries[pos-1] > v) begin
      shadow_entries[pos] = shadow_entries[pos-1];
      pos--;
    end
    shadow_entries[pos] = v;
    shadow_count++;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t p;
    int   k;
    p.read_value = '0;
    p.status     = ST_OK;
    case (kind_t'(r.kind))
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          p.status = ST_FULL;
        end else begin
          place_in_order(r.value);
        end
      end
      KIND_REPLACE: begin
        if (int'(r.index) >= shadow_count) begin
          p.status = ST_RANGE;
        end else begin
          for (k = int'(r.index); k + 1 < shadow_count; k++) begin
            shadow_entries[k] = shadow_entries[k+1];
          end
          shadow_count--;
          place_in_order(r.value);
        end
      end
      KIND_READ: begin
        if (int'(r.index) >= shadow_count) begin
          p.status = ST_RANGE;
        end else begin
          p.read_value = shadow_entries[r.index];
        end
      end
      default: begin
      end
    endcase
    p.entry_count = COUNT_OUT_W'(shadow_count);
    return p;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_rsps.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h with no request waiting", $time, out_rsp);
        end else begin
          want = expected_rsps.pop_front();
          checked++;
          if (out_rsp.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value expected %h, got %h", $time, want.read_value,
                     out_rsp.read_value);
          end
          if (out_rsp.entry_count !== want.entry_count) begin
            errors++;
            $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                     out_rsp.entry_count);
          end
          if (out_rsp.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_rsp.status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(predict_rsp(in_req));
      end
    end
    outstanding = expected_rsps.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the sorted table testbench: clock, reset, request stimulus and receiver stalls.
// Depends on stir_pkg, sorted_table_insert_replace_read and sorted_table_checker.
module tb_top;
  import stir_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 134;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_req    = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  int errors;
  int outstanding;
  int checked;
  int sender_idle_pct = 19;
  int recv_stall_pct  = 68;
  int sent            = 0;
  int cycles          = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  sorted_table_insert_replace_read #(
    .CAPACITY(CAPACITY_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  sorted_table_checker #(
    .CAPACITY(CAPACITY_DEF)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .errors     (errors),
    .outstanding(outstanding),
    .checked    (checked)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic req_t mk(kind_t k, int idx, logic [VALUE_W-1:0] v);
    req_t r;
    r.kind  = k;
    r.index = INDEX_W'(idx);
    r.value = v;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.kind = KIND_INSERT;
    end else if (pick < 65) begin
      r.kind = KIND_REPLACE;
    end else if (pick < 95) begin
      r.kind = KIND_READ;
    end else begin
      r.kind = KIND_NONE;
    end
    r.index = INDEX_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.value = $urandom_range(0, 15);
    end else if (pick < 45) begin
      r.value = '0;
    end else if (pick < 50) begin
      r.value = '1;
    end else begin
      r.value = $urandom;
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_request(mk(KIND_READ, 0, 32'h0));
    send_request(mk(KIND_REPLACE, 0, 32'h1234_5678));
    send_request(mk(KIND_NONE, 15, 32'hFFFF_FFFF));
    send_request(mk(KIND_INSERT, 0, 32'hFFFF_FFFF));
    send_request(mk(KIND_INSERT, 15, 32'h0));
    send_request(mk(KIND_INSERT, 7, 32'h8000_0000));
    send_request(mk(KIND_INSERT, 0, 32'h8000_0000));
    send_request(mk(KIND_READ, 0, 32'h0));
    send_request(mk(KIND_READ, 1, 32'hFFFF_FFFF));
    send_request(mk(KIND_READ, 2, 32'h0));
    send_request(mk(KIND_READ, 3, 32'h0));
    send_request(mk(KIND_READ, 4, 32'h0));
    send_request(mk(KIND_REPLACE, 3, 32'h0));
    send_request(mk(KIND_REPLACE, 0, 32'hFFFF_FFFF));
    send_request(mk(KIND_READ, 0, 32'h0));
    send_request(mk(KIND_READ, 3, 32'h0));
    send_request(mk(KIND_INSERT, 3, 32'h5));
    send_request(mk(KIND_REPLACE, 15, 32'h5));
    send_request(mk(KIND_READ, 15, 32'h0));
    send_request(mk(KIND_NONE, 0, 32'h0));
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        sender_idle_pct = 68;
        recv_stall_pct  = 19;
      end else if (phase == 2) begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_request(random_request());
        if (i == RANDOM_PER_PHASE / 2) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests: directed corners, then random mixes under three pacing modes.",
             sent);
    $display("Checked %0d results against the shadow table.", checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
